// ===== rtl/ius_pkg.sv =====
// shared constants and types for the integer-ratio image upscaler
// no dependencies; every other file but ius_div refers to this package by scoped names
`default_nettype none

package ius_pkg;

  // default sizes handed to the top-level parameters
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_RATIO  = 8;
  localparam int DEF_FRAC_BITS  = 12;

  // fixed field widths
  localparam int COORD_W    = 11;
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH   = 2'd0,
    REG_SRC_HEIGHT  = 2'd1,
    REG_SCALE_RATIO = 2'd2,
    REG_INTERP_MODE = 2'd3
  } reg_idx_t;

  // command codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  // interpolation modes
  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

  // per-item control bits that travel down the back half of the pipeline
  typedef struct packed {
    logic cmp;   // a compute item sits in this stage
    logic rerr;  // its coordinate lies outside the output image
  } item_flags_t;

endpackage

`default_nettype wire

// ===== rtl/ius_cfg.sv =====
// configuration registers and the derived sizes of the source and output images
// depends on ius_pkg
`default_nettype none

module ius_cfg #(
  parameter int MAX_WIDTH  = ius_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ius_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RATIO  = ius_pkg::DEF_MAX_RATIO,
  parameter int WB  = $clog2(MAX_WIDTH + 1),
  parameter int HB  = $clog2(MAX_HEIGHT + 1),
  parameter int NWB = $clog2(MAX_WIDTH * MAX_RATIO + 1),
  parameter int NHB = $clog2(MAX_HEIGHT * MAX_RATIO + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ius_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ius_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [WB-1:0]                  w_eff,
  output logic [HB-1:0]                  h_eff,
  output logic [NWB-1:0]                 nw,
  output logic [NHB-1:0]                 nh,
  output logic [NWB-1:0]                 den_x,
  output logic [NHB-1:0]                 den_y,
  output logic                           mode
);

  localparam int RB = $clog2(MAX_RATIO + 1);

  logic [8:0] src_width;
  logic [8:0] src_height;
  logic [3:0] scale_ratio;
  logic       interp_mode;

  logic [WB-1:0]  w_next;
  logic [HB-1:0]  h_next;
  logic [RB-1:0]  r_next;
  logic [NWB-1:0] nw_next;
  logic [NHB-1:0] nh_next;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width   <= 9'd1;
      src_height  <= 9'd1;
      scale_ratio <= 4'd1;
      interp_mode <= ius_pkg::MODE_BILINEAR;
    end else if (cfg_valid) begin
      unique case (ius_pkg::reg_idx_t'(cfg_index))
        ius_pkg::REG_SRC_WIDTH:   src_width   <= cfg_data[8:0];
        ius_pkg::REG_SRC_HEIGHT:  src_height  <= cfg_data[8:0];
        ius_pkg::REG_SCALE_RATIO: scale_ratio <= cfg_data[3:0];
        ius_pkg::REG_INTERP_MODE: interp_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp the registers into their working ranges
  always_comb begin
    if (src_width == 9'd0) w_next = WB'(1);
    else if (int'(src_width) > MAX_WIDTH) w_next = WB'(MAX_WIDTH);
    else w_next = WB'(src_width);
    if (src_height == 9'd0) h_next = HB'(1);
    else if (int'(src_height) > MAX_HEIGHT) h_next = HB'(MAX_HEIGHT);
    else h_next = HB'(src_height);
    if (scale_ratio == 4'd0) r_next = RB'(1);
    else if (int'(scale_ratio) > MAX_RATIO) r_next = RB'(MAX_RATIO);
    else r_next = RB'(scale_ratio);
    nw_next = NWB'(w_next) * NWB'(r_next);
    nh_next = NHB'(h_next) * NHB'(r_next);
  end

  // derived sizes, a divisor of one stands in for a one-pixel output axis
  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff <= WB'(1);
      h_eff <= HB'(1);
      nw    <= NWB'(1);
      nh    <= NHB'(1);
      den_x <= NWB'(1);
      den_y <= NHB'(1);
      mode  <= ius_pkg::MODE_BILINEAR;
    end else begin
      w_eff <= w_next;
      h_eff <= h_next;
      nw    <= nw_next;
      nh    <= nh_next;
      den_x <= (nw_next <= NWB'(1)) ? NWB'(1) : nw_next - NWB'(1);
      den_y <= (nh_next <= NHB'(1)) ? NHB'(1) : nh_next - NHB'(1);
      mode  <= interp_mode;
    end
  end

`ifndef ASSERT_OFF
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (den_x != '0) && (den_y != '0) && (w_eff != '0) && (h_eff != '0))
    else $error("zero divisor or size after clamping");
`endif

endmodule

`default_nettype wire

// ===== rtl/ius_div.sv =====
// two-lane pipelined restoring divider, one quotient bit per stage, with a sideband
// depends on nothing but its parameters
`default_nettype none

module ius_div #(
  parameter int QW = 20,
  parameter int DB = 17,
  parameter int SB = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0][DB-1:0]   rem0,
  input  logic [1:0][QW-1:0]   low,
  input  logic [1:0][DB-1:0]   den,
  input  logic [SB-1:0]        side_in,
  output logic [1:0][QW-1:0]   quo,
  output logic [SB-1:0]        side_out
);

  logic [1:0][DB-1:0] in_rem  [QW];
  logic [1:0][QW-1:0] in_low  [QW];
  logic [1:0][QW-1:0] in_q    [QW];
  logic [SB-1:0]      in_side [QW];
  logic [1:0][DB-1:0] nxt_rem [QW];
  logic [1:0][QW-1:0] nxt_low [QW];
  logic [1:0][QW-1:0] nxt_q   [QW];
  logic [1:0][DB-1:0] stg_rem [QW];
  logic [1:0][QW-1:0] stg_low [QW];
  logic [1:0][QW-1:0] stg_q   [QW];
  logic [SB-1:0]      stg_side[QW];

  // one shift-compare-subtract per stage and lane
  always_comb begin
    logic [DB:0] trial;
    in_rem[0]  = rem0;
    in_low[0]  = low;
    in_q[0]    = '0;
    in_side[0] = side_in;
    for (int k = 1; k < QW; k++) begin
      in_rem[k]  = stg_rem[k-1];
      in_low[k]  = stg_low[k-1];
      in_q[k]    = stg_q[k-1];
      in_side[k] = stg_side[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      for (int n = 0; n < 2; n++) begin
        trial = {in_rem[k][n], in_low[k][n][QW-1]};
        if (trial >= {1'b0, den[n]}) begin
          nxt_rem[k][n] = DB'(trial - {1'b0, den[n]});
          nxt_q[k][n]   = {in_q[k][n][QW-2:0], 1'b1};
        end else begin
          nxt_rem[k][n] = trial[DB-1:0];
          nxt_q[k][n]   = {in_q[k][n][QW-2:0], 1'b0};
        end
        nxt_low[k][n] = {in_low[k][n][QW-2:0], 1'b0};
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      stg_rem[k] <= nxt_rem[k];
      stg_low[k] <= nxt_low[k];
      stg_q[k]   <= nxt_q[k];
      if (rst) stg_side[k] <= '0;
      else     stg_side[k] <= in_side[k];
    end
  end

  assign quo      = stg_q[QW-1];
  assign side_out = stg_side[QW-1];

endmodule

`default_nettype wire

// ===== rtl/ius_fetch.sv =====
// neighbor addressing, four-bank frame store and pixel selection
// depends on ius_pkg
`default_nettype none

module ius_fetch #(
  parameter int MAX_WIDTH  = ius_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ius_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = ius_pkg::DEF_FRAC_BITS,
  parameter int XB = $clog2(MAX_WIDTH),
  parameter int YB = $clog2(MAX_HEIGHT),
  parameter int WB = $clog2(MAX_WIDTH + 1),
  parameter int HB = $clog2(MAX_HEIGHT + 1),
  parameter int MB = (XB > YB) ? XB : YB,
  parameter int QW = MB + FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [WB-1:0]                 w_eff,
  input  logic [HB-1:0]                 h_eff,
  input  logic                          mode,
  input  logic [QW-1:0]                 qx,
  input  logic [QW-1:0]                 qy,
  input  ius_pkg::item_flags_t          flags_in,
  input  logic                          lwe,
  input  logic [XB-1:0]                 lx,
  input  logic [YB-1:0]                 ly,
  input  logic [ius_pkg::PIX_W-1:0]     pix,
  output ius_pkg::item_flags_t          flags_out,
  output logic [ius_pkg::PIX_W-1:0]     p11,
  output logic [ius_pkg::PIX_W-1:0]     p12,
  output logic [ius_pkg::PIX_W-1:0]     p21,
  output logic [ius_pkg::PIX_W-1:0]     p22,
  output logic [FRAC_BITS-1:0]          fx,
  output logic [FRAC_BITS-1:0]          fy
);

  localparam int HW    = (MAX_WIDTH + 1) / 2;
  localparam int HH    = (MAX_HEIGHT + 1) / 2;
  localparam int DEPTH = HW * HH;
  localparam int AB    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = ius_pkg::PIX_W;

  // index and neighbor logic
  logic [MB:0]   xn, yn;
  logic [XB-1:0] x1, xe, xo;
  logic [YB-1:0] y1, ye, yo;
  logic          cxc, cyc;
  logic [AB-1:0] raddr_next [4];
  logic [AB-1:0] waddr_next;
  logic [3:0]    we_next;

  // first stage registers
  ius_pkg::item_flags_t f1_flags;
  logic [3:0]           f1_we;
  logic [AB-1:0]        f1_waddr;
  logic [PW-1:0]        f1_wdata;
  logic [AB-1:0]        f1_raddr [4];
  logic                 f1_xp, f1_yp, f1_cxc, f1_cyc;
  logic [FRAC_BITS-1:0] f1_fx, f1_fy;

  // read stage registers
  ius_pkg::item_flags_t f2_flags;
  logic [PW-1:0]        rd [4];
  logic                 f2_xp, f2_yp, f2_cxc, f2_cyc;
  logic [FRAC_BITS-1:0] f2_fx, f2_fy;

  logic [1:0] k11, k12, k21, k22;

  // integer positions, nearest rounding and edge clamps
  always_comb begin
    xn = (MB+1)'(qx[QW-1:FRAC_BITS]) + (MB+1)'(qx[FRAC_BITS-1]);
    yn = (MB+1)'(qy[QW-1:FRAC_BITS]) + (MB+1)'(qy[FRAC_BITS-1]);
    if (mode == ius_pkg::MODE_NEAREST) begin
      x1 = (xn >= (MB+1)'(w_eff)) ? XB'(w_eff - 1'b1) : XB'(xn);
      y1 = (yn >= (MB+1)'(h_eff)) ? YB'(h_eff - 1'b1) : YB'(yn);
    end else begin
      x1 = XB'(qx[QW-1:FRAC_BITS]);
      y1 = YB'(qy[QW-1:FRAC_BITS]);
    end
    cxc = (WB'(x1) == w_eff - 1'b1);
    cyc = (HB'(y1) == h_eff - 1'b1);
    xe  = XB'(((XB+1)'(x1) + 1'b1) >> 1);
    xo  = x1 >> 1;
    ye  = YB'(((YB+1)'(y1) + 1'b1) >> 1);
    yo  = y1 >> 1;
    for (int k = 0; k < 4; k++) begin
      raddr_next[k] = AB'(((k / 2 == 1) ? int'(yo) : int'(ye)) * HW
                          + ((k % 2 == 1) ? int'(xo) : int'(xe)));
    end
    waddr_next = AB'(int'(ly >> 1) * HW + int'(lx >> 1));
    we_next = '0;
    we_next[{ly[0], lx[0]}] = lwe;
  end

  // address stage
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_flags <= '0;
      f1_we    <= '0;
    end else begin
      f1_flags <= flags_in;
      f1_we    <= we_next;
    end
    f1_waddr <= waddr_next;
    f1_wdata <= pix;
    for (int k = 0; k < 4; k++) f1_raddr[k] <= raddr_next[k];
    f1_xp  <= x1[0];
    f1_yp  <= y1[0];
    f1_cxc <= cxc;
    f1_cyc <= cyc;
    f1_fx  <= qx[FRAC_BITS-1:0];
    f1_fy  <= qy[FRAC_BITS-1:0];
  end

  // frame store banks by column and row parity
  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [PW-1:0] mem [DEPTH];
    always_ff @(posedge clk) begin
      if (f1_we[k]) mem[f1_waddr] <= f1_wdata;
      rd[k] <= mem[f1_raddr[k]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) f2_flags <= '0;
    else     f2_flags <= f1_flags;
    f2_xp  <= f1_xp;
    f2_yp  <= f1_yp;
    f2_cxc <= f1_cxc;
    f2_cyc <= f1_cyc;
    f2_fx  <= f1_fx;
    f2_fy  <= f1_fy;
  end

  // bank picks for the four neighbors, clamped ones fall back to the near column/row
  always_comb begin
    k11 = {f2_yp, f2_xp};
    k12 = f2_cxc ? k11 : {f2_yp, ~f2_xp};
    k21 = f2_cyc ? k11 : {~f2_yp, f2_xp};
    k22 = {f2_cyc ? f2_yp : ~f2_yp, f2_cxc ? f2_xp : ~f2_xp};
  end

  always_ff @(posedge clk) begin
    if (rst) flags_out <= '0;
    else     flags_out <= f2_flags;
    p11 <= rd[k11];
    p12 <= rd[k12];
    p21 <= rd[k21];
    p22 <= rd[k22];
    fx  <= f2_fx;
    fy  <= f2_fy;
  end

`ifndef ASSERT_OFF
  a_clamp_no_weight: assert property (@(posedge clk) disable iff (rst)
    (f1_flags.cmp && !f1_flags.rerr && mode == ius_pkg::MODE_BILINEAR && f1_cxc)
      |-> (f1_fx == '0))
    else $error("right neighbor clamped while it carries weight");
  a_load_or_compute: assert property (@(posedge clk) disable iff (rst)
    f1_flags.cmp |-> (f1_we == '0))
    else $error("write and compute in the same stage");
`endif

endmodule

`default_nettype wire

// ===== rtl/ius_blend.sv =====
// bilinear weighting, rounding and result registers
// depends on ius_pkg
`default_nettype none

module ius_blend #(
  parameter int FRAC_BITS = ius_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          mode,
  input  ius_pkg::item_flags_t          flags_in,
  input  logic [ius_pkg::PIX_W-1:0]     p11,
  input  logic [ius_pkg::PIX_W-1:0]     p12,
  input  logic [ius_pkg::PIX_W-1:0]     p21,
  input  logic [ius_pkg::PIX_W-1:0]     p22,
  input  logic [FRAC_BITS-1:0]          fx,
  input  logic [FRAC_BITS-1:0]          fy,
  output logic                          done,
  output logic [ius_pkg::PIX_W-1:0]     pixel_out,
  output logic                          range_error
);

  localparam int PW = ius_pkg::PIX_W;
  localparam int TB = FRAC_BITS + PW;
  localparam int AW = 2 * FRAC_BITS + PW;
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic [AW:0] RND = (AW+1)'((64'd1 << (2 * FRAC_BITS - 1)) - 64'd1);

  logic [FRAC_BITS:0] wx0, wy0;

  ius_pkg::item_flags_t a_flags, b_flags;
  logic [TB-1:0]        a_top, a_bot;
  logic [FRAC_BITS-1:0] a_fy;
  logic [PW-1:0]        a_near, b_near;
  logic [AW-1:0]        b_m0, b_m1;

  logic [AW:0]          sum;
  logic [AW-2*FRAC_BITS:0] rnd;
  logic [PW-1:0]        bil;

  assign wx0 = ONE - (FRAC_BITS+1)'(fx);
  assign wy0 = ONE - (FRAC_BITS+1)'(a_fy);

  // horizontal blend of the top and bottom pairs
  always_ff @(posedge clk) begin
    if (rst) a_flags <= '0;
    else     a_flags <= flags_in;
    a_top  <= TB'(wx0) * TB'(p11) + TB'(fx) * TB'(p12);
    a_bot  <= TB'(wx0) * TB'(p21) + TB'(fx) * TB'(p22);
    a_fy   <= fy;
    a_near <= p11;
  end

  // vertical weights
  always_ff @(posedge clk) begin
    if (rst) b_flags <= '0;
    else     b_flags <= a_flags;
    b_m0   <= AW'(wy0) * AW'(a_top);
    b_m1   <= AW'(a_fy) * AW'(a_bot);
    b_near <= a_near;
  end

  // round with ties down and clamp
  always_comb begin
    sum = (AW+1)'(b_m0) + (AW+1)'(b_m1) + RND;
    rnd = sum[AW:2*FRAC_BITS];
    bil = (rnd > (AW-2*FRAC_BITS+1)'(255)) ? 8'd255 : PW'(rnd);
  end

  // result registers, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= b_flags.cmp;
    range_error <= b_flags.rerr;
    if (b_flags.rerr) pixel_out <= '0;
    else if (mode == ius_pkg::MODE_NEAREST) pixel_out <= b_near;
    else pixel_out <= bil;
  end

endmodule

`default_nettype wire

// ===== rtl/image_upscale_nearest_bilinear_core.sv =====
// top level of the integer-ratio nearest / bilinear image upscaler
// depends on ius_pkg, ius_cfg, ius_div, ius_fetch and ius_blend
//
// channel   signals                                  transaction
// command   start busy cmd coord_x coord_y pixel_in  start && !busy at a rising edge
// result    done pixel_out range_error               done high for one cycle
// config    cfg_valid cfg_ready cfg_index cfg_data   cfg_valid && cfg_ready
//
// one command is taken every cycle; busy stays low.
// a compute command passes the input and numerator stages, the one-bit-per-stage divider,
// the fetch stages and the blend stages before its result appears.
// a load command writes the frame store at the same stage where computes read it.
// synchronous reset clears valid bits and config registers; the frame store is not cleared.
// the receiver cannot stall, so the pipeline never holds.
`default_nettype none

module image_upscale_nearest_bilinear_core #(
  parameter int MAX_WIDTH  = ius_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ius_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RATIO  = ius_pkg::DEF_MAX_RATIO,
  parameter int FRAC_BITS  = ius_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cmd,
  input  logic [ius_pkg::COORD_W-1:0]    coord_x,
  input  logic [ius_pkg::COORD_W-1:0]    coord_y,
  input  logic [ius_pkg::PIX_W-1:0]      pixel_in,
  output logic                           done,
  output logic [ius_pkg::PIX_W-1:0]      pixel_out,
  output logic                           range_error,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ius_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ius_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW  = ius_pkg::COORD_W;
  localparam int PW  = ius_pkg::PIX_W;
  localparam int WB  = $clog2(MAX_WIDTH + 1);
  localparam int HB  = $clog2(MAX_HEIGHT + 1);
  localparam int XB  = $clog2(MAX_WIDTH);
  localparam int YB  = $clog2(MAX_HEIGHT);
  localparam int MB  = (XB > YB) ? XB : YB;
  localparam int NWB = $clog2(MAX_WIDTH * MAX_RATIO + 1);
  localparam int NHB = $clog2(MAX_HEIGHT * MAX_RATIO + 1);
  localparam int DB  = (NWB > NHB) ? NWB : NHB;
  localparam int NB  = MB + CW;
  localparam int QW  = MB + FRAC_BITS;
  localparam int SB  = 3 + XB + YB + PW;
  localparam int LAT = QW + 8;

  logic [WB-1:0]  w_eff;
  logic [HB-1:0]  h_eff;
  logic [NWB-1:0] nw, den_x;
  logic [NHB-1:0] nh, den_y;
  logic           mode;

  logic accept;

  // input stage
  logic          s0_valid;
  logic          s0_cmd;
  logic [CW-1:0] s0_x, s0_y;
  logic [PW-1:0] s0_pix;

  // numerator stage
  logic          s1_cmp, s1_rerr, s1_lwe;
  logic [XB-1:0] s1_lx;
  logic [YB-1:0] s1_ly;
  logic [PW-1:0] s1_pix;
  logic [NB-1:0] s1_numx, s1_numy;

  logic [1:0][DB-1:0] div_rem0, div_den;
  logic [1:0][QW-1:0] div_low, div_quo;
  logic [SB-1:0]      side_out;

  ius_pkg::item_flags_t d_flags, f_flags;
  logic                 d_lwe;
  logic [XB-1:0]        d_lx;
  logic [YB-1:0]        d_ly;
  logic [PW-1:0]        d_pix;

  logic [PW-1:0]        p11, p12, p21, p22;
  logic [FRAC_BITS-1:0] fx, fy;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  ius_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_RATIO (MAX_RATIO),
    .WB        (WB),
    .HB        (HB),
    .NWB       (NWB),
    .NHB       (NHB)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .nw       (nw),
    .nh       (nh),
    .den_x    (den_x),
    .den_y    (den_y),
    .mode     (mode)
  );

  // capture the command
  always_ff @(posedge clk) begin
    if (rst) s0_valid <= 1'b0;
    else     s0_valid <= accept;
    s0_cmd <= cmd;
    s0_x   <= coord_x;
    s0_y   <= coord_y;
    s0_pix <= pixel_in;
  end

  // range checks and mapping numerators (w-1)*i, (h-1)*j
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_cmp <= 1'b0;
      s1_lwe <= 1'b0;
    end else begin
      s1_cmp <= s0_valid && (s0_cmd == ius_pkg::CMD_COMPUTE);
      s1_lwe <= s0_valid && (s0_cmd == ius_pkg::CMD_LOAD)
                && (s0_x < w_eff) && (s0_y < h_eff);
    end
    s1_rerr <= (s0_x >= nw) || (s0_y >= nh);
    s1_lx   <= XB'(s0_x);
    s1_ly   <= YB'(s0_y);
    s1_pix  <= s0_pix;
    s1_numx <= NB'(w_eff - 1'b1) * NB'(s0_x);
    s1_numy <= NB'(h_eff - 1'b1) * NB'(s0_y);
  end

  // dividend is numerator * 2^FRAC_BITS, its top bits start the remainder
  assign div_rem0[0] = DB'(s1_numx >> MB);
  assign div_rem0[1] = DB'(s1_numy >> MB);
  assign div_low[0]  = {s1_numx[MB-1:0], {FRAC_BITS{1'b0}}};
  assign div_low[1]  = {s1_numy[MB-1:0], {FRAC_BITS{1'b0}}};
  assign div_den[0]  = DB'(den_x);
  assign div_den[1]  = DB'(den_y);

  ius_div #(
    .QW(QW),
    .DB(DB),
    .SB(SB)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .rem0    (div_rem0),
    .low     (div_low),
    .den     (div_den),
    .side_in ({s1_cmp, s1_rerr, s1_lwe, s1_lx, s1_ly, s1_pix}),
    .quo     (div_quo),
    .side_out(side_out)
  );

  assign {d_flags.cmp, d_flags.rerr, d_lwe, d_lx, d_ly, d_pix} = side_out;

  ius_fetch #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .FRAC_BITS (FRAC_BITS),
    .XB        (XB),
    .YB        (YB),
    .WB        (WB),
    .HB        (HB),
    .MB        (MB),
    .QW        (QW)
  ) u_fetch (
    .clk      (clk),
    .rst      (rst),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .mode     (mode),
    .qx       (div_quo[0]),
    .qy       (div_quo[1]),
    .flags_in (d_flags),
    .lwe      (d_lwe),
    .lx       (d_lx),
    .ly       (d_ly),
    .pix      (d_pix),
    .flags_out(f_flags),
    .p11      (p11),
    .p12      (p12),
    .p21      (p21),
    .p22      (p22),
    .fx       (fx),
    .fy       (fy)
  );

  ius_blend #(
    .FRAC_BITS(FRAC_BITS)
  ) u_blend (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .flags_in   (f_flags),
    .p11        (p11),
    .p12        (p12),
    .p21        (p21),
    .p22        (p22),
    .fx         (fx),
    .fy         (fy),
    .done       (done),
    .pixel_out  (pixel_out),
    .range_error(range_error)
  );

`ifndef ASSERT_OFF
  a_compute_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == ius_pkg::CMD_COMPUTE) |-> ##LAT done)
    else $error("compute transaction without result at fixed latency");
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && range_error) |-> (pixel_out == '0))
    else $error("out-of-range result with nonzero pixel");
`endif

endmodule

`default_nettype wire
